// ===== hdl/n_queens_solution_enumerator_assert.svh =====
// Assertion macros for the N-queens enumerator checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef N_QUEENS_SOLUTION_ENUMERATOR_ASSERT_SVH
`define N_QUEENS_SOLUTION_ENUMERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NQSE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nqse: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NQSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nqse: next-cycle check failed");

`endif

// ===== hdl/nqse_pkg.sv =====
// Shared types, constants and helper functions for the N-queens enumerator.
// Used by the top level, the port checker and the testbench; depends on nothing else.
package nqse_pkg;

  localparam int MAX_BOARD = 16;
  localparam int COL_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int PLACE_W   = COL_W * MAX_BOARD;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [PLACE_W-1:0] place_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOP,
    ST_CHECK,
    ST_LIFT,
    ST_PACK,
    ST_EMIT
  } state_t;

  // Zero behaves as one; anything above the largest board saturates.
  function automatic size_t eff_size(size_t b);
    size_t n;
    n = b;
    if (b == '0) begin
      n = size_t'(1);
    end else if (b > size_t'(MAX_BOARD)) begin
      n = size_t'(MAX_BOARD);
    end
    return n;
  endfunction

  // True when the queen in row qr, column qc attacks square (row, cand).
  function automatic logic attacks(col_t qr, col_t qc, size_t row, size_t cand);
    logic [SIZE_W:0] lhs_a;
    logic [SIZE_W:0] rhs_a;
    logic [SIZE_W:0] lhs_b;
    logic [SIZE_W:0] rhs_b;
    lhs_a = {2'b00, qr} + {1'b0, cand};
    rhs_a = {1'b0, row} + {2'b00, qc};
    lhs_b = {2'b00, qr} + {2'b00, qc};
    rhs_b = {1'b0, row} + {1'b0, cand};
    return ({1'b0, qc} == cand) || (lhs_a == rhs_a) || (lhs_b == rhs_b);
  endfunction

endpackage

// ===== hdl/nqse_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module nqse_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/n_queens_solution_enumerator.sv =====
// N-queens enumerator: one request yields the next solution or an exhausted flag.
// The run time of a request is data dependent: each candidate test reads one stack entry
// per cycle for every placed row, each lift reads the top entry in ST_TOP and pops it in
// ST_LIFT, and unloading a solution reads the rows in order in ST_PACK before ST_EMIT.
// One request is in flight at a time; the column stack RAM read port sets the pace.
// Synchronous reset clears the search and sets the board size to 8; the RAM is not cleared.
module n_queens_solution_enumerator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nqse_pkg::place_t      out_placement,
  output logic                  out_found,
  output logic                  out_exhausted,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  nqse_pkg::size_t       cfg_board_size
);
  import nqse_pkg::*;

  state_t state_r, state_nxt;
  size_t  board_r, board_nxt;
  size_t  depth_r, depth_nxt;
  size_t  nc_r, nc_nxt;
  logic   done_r, done_nxt;
  size_t  cand_r, cand_nxt;
  col_t   idx_r, idx_nxt;
  place_t pk_r, pk_nxt;
  logic   found_r, found_nxt;
  logic   out_valid_r, out_valid_nxt;
  place_t out_placement_r, out_placement_nxt;
  logic   out_found_r, out_found_nxt;
  logic   out_exhausted_r, out_exhausted_nxt;

  logic   ram_we;
  col_t   ram_waddr;
  col_t   ram_wdata;
  col_t   ram_raddr;
  col_t   ram_rdata;

  size_t  n;
  size_t  n_m1;
  size_t  depth_m1;
  logic   in_xfer;
  logic   cfg_xfer;
  logic   out_free;
  logic   hit;
  logic   done_eff;

  nqse_ram #(.WIDTH(COL_W), .DEPTH(MAX_BOARD)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign n        = eff_size(board_r);
  assign n_m1     = n - 1'b1;
  assign depth_m1 = depth_r - 1'b1;
  assign cfg_ready = (state_r == ST_IDLE);
  // A pending configuration write goes first so it is never mixed with a request.
  assign in_stall = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_xfer = cfg_valid && cfg_ready;
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !(out_valid_r && out_stall);
  assign hit      = attacks(idx_r, ram_rdata, depth_r, cand_r);
  assign done_eff = done_r && !in_restart;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = done_eff ? ST_EMIT : ST_TOP;
        end
      end
      ST_TOP: begin
        if (depth_r >= n) begin
          state_nxt = ST_PACK;
        end else if (nc_r >= n) begin
          state_nxt = (depth_r == '0) ? ST_EMIT : ST_LIFT;
        end else if (depth_r == '0) begin
          state_nxt = ST_TOP;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (hit || ({1'b0, idx_r} == depth_m1)) begin
          state_nxt = ST_TOP;
        end
      end
      ST_LIFT: begin
        state_nxt = ST_TOP;
      end
      ST_PACK: begin
        if ({1'b0, idx_r} == n_m1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and stack RAM control.
  always_comb begin
    board_nxt         = board_r;
    depth_nxt         = depth_r;
    nc_nxt            = nc_r;
    done_nxt          = done_r;
    cand_nxt          = cand_r;
    idx_nxt           = idx_r;
    pk_nxt            = pk_r;
    found_nxt         = found_r;
    out_valid_nxt     = out_valid_r && out_stall;
    out_placement_nxt = out_placement_r;
    out_found_nxt     = out_found_r;
    out_exhausted_nxt = out_exhausted_r;
    ram_we            = 1'b0;
    ram_waddr         = depth_r[COL_W-1:0];
    ram_wdata         = cand_r[COL_W-1:0];
    ram_raddr         = '0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_xfer) begin
          board_nxt = cfg_board_size;
          depth_nxt = '0;
          nc_nxt    = '0;
          done_nxt  = 1'b0;
        end else if (in_xfer) begin
          if (in_restart) begin
            depth_nxt = '0;
            nc_nxt    = '0;
            done_nxt  = 1'b0;
          end
          found_nxt = 1'b0;
          pk_nxt    = '0;
        end
      end
      ST_TOP: begin
        if (depth_r >= n) begin
          idx_nxt   = '0;
          ram_raddr = '0;
        end else if (nc_r >= n) begin
          if (depth_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            ram_raddr = depth_m1[COL_W-1:0];
          end
        end else if (depth_r == '0) begin
          // First row has nothing to conflict with.
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = nc_r[COL_W-1:0];
          depth_nxt = size_t'(1);
          nc_nxt    = '0;
        end else begin
          cand_nxt  = nc_r;
          idx_nxt   = '0;
          ram_raddr = '0;
        end
      end
      ST_CHECK: begin
        if (hit) begin
          nc_nxt = cand_r + 1'b1;
        end else if ({1'b0, idx_r} == depth_m1) begin
          ram_we    = 1'b1;
          depth_nxt = depth_r + 1'b1;
          nc_nxt    = '0;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      ST_LIFT: begin
        depth_nxt = depth_m1;
        nc_nxt    = {1'b0, ram_rdata} + 1'b1;
      end
      ST_PACK: begin
        pk_nxt[idx_r*COL_W +: COL_W] = ram_rdata;
        if ({1'b0, idx_r} == n_m1) begin
          // The last row just read is the queen lifted for the next resume.
          depth_nxt = depth_m1;
          nc_nxt    = {1'b0, ram_rdata} + 1'b1;
          found_nxt = 1'b1;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_placement_nxt = found_r ? pk_r : '0;
          out_found_nxt     = found_r;
          out_exhausted_nxt = !found_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      board_r     <= size_t'(8);
      depth_r     <= '0;
      nc_r        <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      board_r     <= board_nxt;
      depth_r     <= depth_nxt;
      nc_r        <= nc_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r          <= cand_nxt;
    idx_r           <= idx_nxt;
    pk_r            <= pk_nxt;
    found_r         <= found_nxt;
    out_placement_r <= out_placement_nxt;
    out_found_r     <= out_found_nxt;
    out_exhausted_r <= out_exhausted_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_placement = out_placement_r;
  assign out_found     = out_found_r;
  assign out_exhausted = out_exhausted_r;

endmodule

// ===== hdl/nqse_checker.sv =====
// Port-level checker for the N-queens enumerator, bound to the top level.
// Depends on nqse_pkg and the assertion macro header.
`include "n_queens_solution_enumerator_assert.svh"

module nqse_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input nqse_pkg::place_t out_placement,
  input logic             out_found,
  input logic             out_exhausted,
  input logic             cfg_valid,
  input logic             cfg_ready
);
  import nqse_pkg::*;

  logic   in_xfer;
  logic   cfg_xfer;
  place_t zero_place;

  assign in_xfer    = in_valid && !in_stall;
  assign cfg_xfer   = cfg_valid && cfg_ready;
  assign zero_place = '0;

  // Every result is either a new solution or the exhausted flag, never both.
  `NQSE_ASSERT_IMPL(a_found_xor_exh, out_valid, out_found != out_exhausted)
  // An exhausted result carries an empty placement.
  `NQSE_ASSERT_IMPL(a_exh_zero, out_valid && out_exhausted, out_placement == zero_place)
  // A configuration write and a request transfer never share a cycle.
  `NQSE_ASSERT_IMPL(a_cfg_excl, cfg_xfer, !in_xfer)
  // A stalled result holds.
  `NQSE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_placement))

endmodule

bind n_queens_solution_enumerator nqse_checker u_nqse_checker (.*);

// ===== tb/n_queens_solution_enumerator_checker.sv =====
`timescale 1ns / 100ps
// Checker for the N-queens enumerator: watches the request, result and board size
// channels, predicts each answer by its own backtracking search and compares.
// Depends on nqse_pkg for the port types.
module n_queens_solution_enumerator_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_restart,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  nqse_pkg::place_t      out_placement,
  input  logic                  out_found,
  input  logic                  out_exhausted,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  nqse_pkg::size_t       cfg_board_size,
  output int unsigned           fail_count,
  output int unsigned           pending
);
  import nqse_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    place_t placement;
    logic   found;
    logic   exhausted;
  } answer_t;

  answer_t answer_q[$];

  // Shadow copy of the search state.
  col_t    queen_col[MAX_BOARD];
  int      queens;
  int      next_col;
  bit      search_over;
  size_t   size_reg;

  function automatic int active_size();
    if (size_reg == '0) begin
      return 1;
    end
    if (size_reg > size_t'(MAX_BOARD)) begin
      return MAX_BOARD;
    end
    return int'(size_reg);
  endfunction

  function automatic bit safe_square(int row, int col);
    int q;
    for (int i = 0; i < row; i++) begin
      q = int'(queen_col[i]);
      if (q == col || i - q == row - col || i + q == row + col) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic clear_search();
    foreach (queen_col[i]) begin
      queen_col[i] = '0;
    end
    queens      = 0;
    next_col    = 0;
    search_over = 1'b0;
  endtask

  task automatic lift_queen();
    queens   = queens - 1;
    next_col = int'(queen_col[queens]) + 1;
  endtask

  // Runs the search up to the next full placement, or until the tree is used up.
  task automatic advance_search(input logic restart, output answer_t ans);
    int  n;
    bit  busy;
    bit  placed;
    ans.placement = '0;
    ans.found     = 1'b0;
    ans.exhausted = 1'b1;
    if (restart) begin
      clear_search();
    end
    if (search_over) begin
      return;
    end
    n    = active_size();
    busy = 1'b1;
    while (busy) begin
      if (queens >= n) begin
        for (int r = 0; r < n; r++) begin
          ans.placement[4*r +: 4] = queen_col[r];
        end
        ans.found     = 1'b1;
        ans.exhausted = 1'b0;
        lift_queen();
        busy = 1'b0;
      end else begin
        placed = 1'b0;
        for (int c = next_col; c < n && !placed; c++) begin
          if (safe_square(queens, c)) begin
            queen_col[queens] = col_t'(c);
            queens   = queens + 1;
            next_col = 0;
            placed   = 1'b1;
          end
        end
        if (!placed) begin
          if (queens == 0) begin
            search_over = 1'b1;
            busy        = 1'b0;
          end else begin
            lift_queen();
          end
        end
      end
    end
  endtask

  task automatic flag_result(input string why, input answer_t want);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected placement %h found %b exhausted %b, got %h %b %b",
               $realtime, why, want.placement, want.found, want.exhausted,
               out_placement, out_found, out_exhausted);
    end
  endtask

  always @(posedge clk) begin : watch_channels
    answer_t want;
    answer_t fresh;
    if (!rst_n) begin
      size_reg = size_t'(8);
      clear_search();
      answer_q.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_reg = cfg_board_size;
        clear_search();
      end
      // The oldest answer is retired before a new request is predicted.
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          want.placement = '0;
          want.found     = 1'bx;
          want.exhausted = 1'bx;
          flag_result("result with no request waiting", want);
        end else begin
          want = answer_q.pop_front();
          if (out_placement !== want.placement || out_found !== want.found ||
              out_exhausted !== want.exhausted) begin
            flag_result("wrong result", want);
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_search(in_restart, fresh);
        answer_q.insert(answer_q.size(), fresh);
      end
      pending <= answer_q.size();
    end
  end

endmodule

// ===== tb/n_queens_solution_enumerator_test.sv =====
`timescale 1ns / 100ps
// Top of the N-queens enumerator testbench: clock, reset, request and board size
// stimulus, result stalls and the verdict. Depends on nqse_pkg, the enumerator
// and n_queens_solution_enumerator_checker.
module n_queens_solution_enumerator_test;
  import nqse_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 10_000_000;
  localparam int unsigned RANDOM_ITEMS = 270;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_restart;
  logic        out_valid;
  logic        out_stall;
  place_t      out_placement;
  logic        out_found;
  logic        out_exhausted;
  logic        cfg_valid;
  logic        cfg_ready;
  size_t       cfg_board_size;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned hold_budget;
  int unsigned idle_cycles;
  stall_kind_t stall_mode;

  n_queens_solution_enumerator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_placement  (out_placement),
    .out_found      (out_found),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_board_size (cfg_board_size)
  );

  n_queens_solution_enumerator_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_placement  (out_placement),
    .out_found      (out_found),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_board_size (cfg_board_size),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: a long hold-off when one is requested, otherwise the phase's pattern.
  initial begin
    int unsigned tick;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_budget > 0) begin
        out_stall <= 1'b1;
        hold_budget--;
      end else begin
        case (stall_mode)
          STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
          STALL_PERIODIC: out_stall <= ((tick % 7) < 3);
          default:        out_stall <= 1'b0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one request and holds it until the transfer.
  task automatic put_request(input logic restart);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic sender_pause(input int unsigned cycles);
    @(negedge clk);
    in_valid   <= 1'b0;
    in_restart <= 1'($urandom_range(0, 1));
    repeat (cycles - 1) @(posedge clk);
  endtask

  task automatic drain();
    sender_pause(1);
    wait (pending == 0);
  endtask

  // Board size writes go in only once every answer has come back.
  task automatic write_size(input size_t value);
    drain();
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_board_size <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid      <= 1'b0;
    cfg_board_size <= size_t'($urandom_range(0, 31));
  endtask

  // Mostly mid-sized boards; larger ones are slow to search, so they are rare.
  function automatic size_t pick_size();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r <= 3) begin
      return size_t'($urandom_range(1, 3));
    end else if (r <= 15) begin
      return size_t'($urandom_range(4, 8));
    end
    return size_t'($urandom_range(9, 12));
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned phase_len;
    int unsigned burst_left;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_restart     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_board_size = '0;
    hold_budget    = 0;
    idle_cycles    = 0;
    stall_mode     = STALL_NONE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A resume straight after reset starts on an empty board of the default size.
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b1);

    // Size zero acts as one: one solution, then exhausted on every resume.
    write_size('0);
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);
    write_size(size_t'(1));
    put_request(1'b1);
    put_request(1'b0);

    // No solutions at all on a board of two.
    write_size(size_t'(2));
    put_request(1'b0);
    put_request(1'b1);

    stall_mode = STALL_LIGHT;
    write_size(size_t'(4));
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b1);

    // Rewriting the size clears the search even when the value is unchanged.
    write_size(size_t'(4));
    put_request(1'b0);
    write_size(size_t'(4));
    put_request(1'b0);

    // The result side holds off while requests keep coming, so the input backs up.
    write_size(size_t'(6));
    drain();
    hold_budget = 600;
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);
    put_request(1'b0);

    // Sizes beyond the largest board saturate; one full sixteen-queen placement.
    stall_mode = STALL_NONE;
    write_size(size_t'(16));
    write_size(size_t'(31));
    put_request(1'b1);
    write_size(size_t'(13));
    put_request(1'b0);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        write_size(pick_size());
      end else begin
        drain();
      end
      stall_mode = stall_kind_t'($urandom_range(0, 3));
      phase_len  = $urandom_range(3, 30);
      burst_left = 0;
      for (int unsigned k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 2) != 0) begin
            sender_pause($urandom_range(1, 30));
          end
          burst_left = $urandom_range(1, 8);
        end
        put_request($urandom_range(0, 11) == 0);
        burst_left--;
        random_sent++;
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nqse_pkg.sv
hdl/nqse_ram.sv
hdl/n_queens_solution_enumerator.sv
hdl/nqse_checker.sv
tb/n_queens_solution_enumerator_checker.sv
tb/n_queens_solution_enumerator_test.sv
